// ===== hdl/armt_pkg.sv =====
// ----------------------------------------------------------------------------
// armt_pkg: shared definitions for the address region map table
// Sizes, command and status codes, sequencer states and the structs
// passed between the table store, the overlap unit and the sequencer.
// ----------------------------------------------------------------------------
package armt_pkg;

	// Table geometry and address space.
	localparam int MAX_REGIONS = 16;
	localparam int ADDR_BITS   = 48;
	localparam int PAGE_BITS   = 12;

	// Derived widths.
	localparam int SLOT_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int CNT_W  = $clog2(MAX_REGIONS + 1);
	localparam int RC_W   = 5;
	localparam int CMP_W  = (CNT_W > RC_W) ? CNT_W : RC_W;
	localparam int PG_W   = ADDR_BITS - PAGE_BITS;
	localparam int BASE_W = 48;
	localparam int SIZE_W = 49;
	localparam int SUM_W  = SIZE_W + 1;
	localparam int IDX_W  = 8;
	localparam int TGT_W  = 8;

	// Command codes.
	localparam logic [1:0] CMD_MAP   = 2'd0;
	localparam logic [1:0] CMD_UNMAP = 2'd1;
	localparam logic [1:0] CMD_PROG  = 2'd2;

	// Status codes.
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_RANGE = 2'd1;
	localparam logic [1:0] STAT_PARAM = 2'd2;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_FINISH
	} armt_state_t;

	// One table entry as seen on the read side.
	typedef struct packed {
		logic             valid;
		logic [PG_W-1:0]  base_page;
		logic [PG_W-1:0]  end_page;
		logic [TGT_W-1:0] target;
	} armt_entry_t;

	// Table write port: set_valid low clears the entry.
	typedef struct packed {
		logic              en;
		logic              set_valid;
		logic [SLOT_W-1:0] idx;
		logic [PG_W-1:0]   base_page;
		logic [PG_W-1:0]   end_page;
		logic [TGT_W-1:0]  target;
	} armt_wr_t;

	// Sequencer controls towards the datapath.
	typedef struct packed {
		logic busy;
		logic check;
		logic scan;
		logic finish;
	} armt_ctrl_t;

	// Datapath flags towards the sequencer.
	typedef struct packed {
		logic scan_go;
		logic scan_last;
	} armt_flags_t;

endpackage

// ===== hdl/armt_table.sv =====
// ----------------------------------------------------------------------------
// armt_table: region entry store
// Holds the valid bits, base pages, end pages and targets of all slots,
// with one write port and one read port addressed by the scan index.
// ----------------------------------------------------------------------------
module armt_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  armt_pkg::armt_wr_t            wr,
	input  logic [armt_pkg::SLOT_W-1:0]   rd_idx,
	output armt_pkg::armt_entry_t         rd
);
	import armt_pkg::*;

	logic [MAX_REGIONS-1:0] valid_q;
	logic [PG_W-1:0]        base_q   [MAX_REGIONS];
	logic [PG_W-1:0]        end_q    [MAX_REGIONS];
	logic [TGT_W-1:0]       target_q [MAX_REGIONS];

	// Valid bits are cleared at reset; an invalid entry never takes part.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.idx] <= wr.set_valid;
		end
	end

	// Entry payload is written only when the entry becomes valid.
	always_ff @(posedge clk) begin
		if (wr.en && wr.set_valid) begin
			base_q[wr.idx]   <= wr.base_page;
			end_q[wr.idx]    <= wr.end_page;
			target_q[wr.idx] <= wr.target;
		end
	end

	// Read side for the scan.
	always_comb begin
		rd.valid     = valid_q[rd_idx];
		rd.base_page = base_q[rd_idx];
		rd.end_page  = end_q[rd_idx];
		rd.target    = target_q[rd_idx];
	end

endmodule

// ===== hdl/armt_ovl.sv =====
// ----------------------------------------------------------------------------
// armt_ovl: shared overlap comparator
// Compares the new page range against one table entry per cycle, with
// inclusive end pages on both sides.
// ----------------------------------------------------------------------------
module armt_ovl (
	input  logic [armt_pkg::PG_W-1:0] new_base_page,
	input  logic [armt_pkg::PG_W-1:0] new_end_page,
	input  armt_pkg::armt_entry_t     entry,
	output logic                      hit
);
	import armt_pkg::*;

	// Two ranges overlap when each starts no later than the other ends.
	always_comb begin
		hit = entry.valid
			&& (new_base_page <= entry.end_page)
			&& (entry.base_page <= new_end_page);
	end

endmodule

// ===== hdl/armt_ctrl.sv =====
// ----------------------------------------------------------------------------
// armt_ctrl: command sequencer
// Steps each command through check, the optional slot scan and the
// finishing cycle that updates the table and issues the result.
// ----------------------------------------------------------------------------
module armt_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  armt_pkg::armt_flags_t flags,
	output armt_pkg::armt_ctrl_t  ctrl
);
	import armt_pkg::*;

	armt_state_t state_q;
	armt_state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = flags.scan_go ? ST_SCAN : ST_FINISH;
			end
			ST_SCAN: begin
				if (flags.scan_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs.
	always_comb begin
		ctrl = '0;
		case (state_q)
			ST_IDLE: begin
				ctrl.busy = 1'b0;
			end
			ST_CHECK: begin
				ctrl.busy  = 1'b1;
				ctrl.check = 1'b1;
			end
			ST_SCAN: begin
				ctrl.busy = 1'b1;
				ctrl.scan = 1'b1;
			end
			ST_FINISH: begin
				ctrl.busy   = 1'b1;
				ctrl.finish = 1'b1;
			end
			default: begin
				ctrl = '0;
			end
		endcase
	end

endmodule

// ===== hdl/address_region_map_table.sv =====
// ----------------------------------------------------------------------------
// address_region_map_table: address region map with overlap checking
// Maps, unmaps and programs address regions in a small table and keeps a
// global enable bit; a map scans the usable slots one per cycle.
//
// Channel  Direction  Handshake              Payload
// command  in         start / busy           cmd, region_base, region_size,
//                                            dest_port, slot_index, batch_last
// result   out        done (one-cycle pulse) status, assigned_slot, map_enabled
// config   in         cfg_valid / cfg_ready  slot_limit
//
// A map scans the usable slots one entry per cycle through the shared
// comparator; the scan stops at the first overlap and is skipped for a bad
// range or no usable slot. Other commands go from check straight to the
// finishing step. busy is high from the cycle after acceptance until done
// shows, when the next may be taken. Reset clears the valid bits and the
// enable; results cannot be stalled.
// ----------------------------------------------------------------------------
module address_region_map_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    cmd,
	input  logic [armt_pkg::BASE_W-1:0]   region_base,
	input  logic [armt_pkg::SIZE_W-1:0]   region_size,
	input  logic [armt_pkg::TGT_W-1:0]    dest_port,
	input  logic [armt_pkg::IDX_W-1:0]    slot_index,
	input  logic                          batch_last,
	output logic                          done,
	output logic [1:0]                    status,
	output logic [armt_pkg::IDX_W-1:0]    assigned_slot,
	output logic                          map_enabled,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [armt_pkg::RC_W-1:0]     slot_limit
);
	import armt_pkg::*;

	localparam logic [SUM_W-1:0] ADDR_LIMIT = SUM_W'(1) << ADDR_BITS;

	armt_ctrl_t        ctrl;
	armt_flags_t       flags;
	armt_wr_t          wr;
	armt_entry_t       entry;
	logic              accept;
	logic              hit;

	logic [RC_W-1:0]   slot_limit_q;
	logic [CNT_W-1:0]  eff_count;
	logic              enable_q;
	logic              done_q;
	logic [1:0]        status_q;
	logic [IDX_W-1:0]  slot_q;

	logic [1:0]        cmd_q;
	logic [BASE_W-1:0] base_q;
	logic [SIZE_W-1:0] size_q;
	logic [TGT_W-1:0]  target_q;
	logic [IDX_W-1:0]  idx_q;
	logic              last_q;
	logic [SUM_W-1:0]  sum_q;

	logic              fits_c;
	logic [SUM_W-1:0]  end_addr_c;
	logic              fits_q;
	logic [PG_W-1:0]   new_bp_q;
	logic [PG_W-1:0]   new_ep_q;

	logic [SLOT_W-1:0] scan_idx_q;
	logic              found_q;
	logic              overlap_q;
	logic [SLOT_W-1:0] free_q;

	logic              aligned_c;
	logic              idx_ok_c;
	logic [1:0]        status_c;
	logic [IDX_W-1:0]  slot_c;
	logic              enable_c;

	assign accept    = start && !ctrl.busy;
	assign busy      = ctrl.busy;
	assign cfg_ready = !ctrl.busy;
	assign done          = done_q;
	assign status        = status_q;
	assign assigned_slot = slot_q;
	assign map_enabled   = enable_q;

	// Usable slot count, limited to the implemented slots.
	assign eff_count = (CMP_W'(slot_limit_q) < CMP_W'(MAX_REGIONS))
		? CNT_W'(slot_limit_q) : CNT_W'(MAX_REGIONS);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_limit_q <= RC_W'(16);
		end else if (cfg_valid && cfg_ready) begin
			slot_limit_q <= slot_limit;
		end
	end

	// Command capture; the end address sum is formed here.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= cmd;
			base_q   <= region_base;
			size_q   <= region_size;
			target_q <= dest_port;
			idx_q    <= slot_index;
			last_q   <= batch_last;
			sum_q    <= SUM_W'(region_base) + SUM_W'(region_size);
		end
	end

	// Range check and page numbers of the new region.
	assign fits_c     = (size_q != '0) && (sum_q <= ADDR_LIMIT);
	assign end_addr_c = sum_q - SUM_W'(1);

	always_ff @(posedge clk) begin
		if (ctrl.check) begin
			fits_q   <= fits_c;
			new_bp_q <= base_q[ADDR_BITS-1:PAGE_BITS];
			new_ep_q <= end_addr_c[ADDR_BITS-1:PAGE_BITS];
		end
	end

	assign flags.scan_go = (cmd_q == CMD_MAP) && fits_c && (eff_count != '0);
	assign flags.scan_last = hit
		|| ((CNT_W'(scan_idx_q) + CNT_W'(1)) == eff_count);

	// Slot scan: first free slot and any overlap, one entry per cycle.
	always_ff @(posedge clk) begin
		if (ctrl.check) begin
			scan_idx_q <= '0;
			found_q    <= 1'b0;
			overlap_q  <= 1'b0;
			free_q     <= '0;
		end else if (ctrl.scan) begin
			scan_idx_q <= scan_idx_q + SLOT_W'(1);
			if (hit) begin
				overlap_q <= 1'b1;
			end else if (!entry.valid && !found_q) begin
				found_q <= 1'b1;
				free_q  <= scan_idx_q;
			end
		end
	end

	armt_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.rd_idx (scan_idx_q),
		.rd     (entry)
	);

	armt_ovl u_ovl (
		.new_base_page (new_bp_q),
		.new_end_page  (new_ep_q),
		.entry         (entry),
		.hit           (hit)
	);

	armt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	// Outcome of the command, table update and new enable.
	assign aligned_c = (base_q[PAGE_BITS-1:0] == '0) && (size_q[PAGE_BITS-1:0] == '0);
	assign idx_ok_c  = idx_q < IDX_W'(eff_count);

	always_comb begin
		status_c     = STAT_PARAM;
		slot_c       = idx_q;
		enable_c     = enable_q;
		wr.en        = 1'b0;
		wr.set_valid = 1'b1;
		wr.idx       = idx_q[SLOT_W-1:0];
		wr.base_page = new_bp_q;
		wr.end_page  = new_ep_q;
		wr.target    = target_q;
		case (cmd_q)
			CMD_MAP: begin
				slot_c = '0;
				wr.idx = free_q;
				if (!fits_q || overlap_q) begin
					status_c = STAT_PARAM;
				end else if (!found_q) begin
					status_c = STAT_RANGE;
				end else if (!aligned_c) begin
					status_c = STAT_PARAM;
					enable_c = 1'b0;
				end else begin
					status_c = STAT_OK;
					slot_c   = IDX_W'(free_q);
					enable_c = 1'b1;
					wr.en    = ctrl.finish;
				end
			end
			CMD_UNMAP: begin
				wr.set_valid = 1'b0;
				if (!idx_ok_c) begin
					status_c = STAT_RANGE;
					enable_c = 1'b0;
				end else begin
					status_c = STAT_OK;
					enable_c = 1'b1;
					wr.en    = ctrl.finish;
				end
			end
			CMD_PROG: begin
				if (!idx_ok_c) begin
					status_c = STAT_RANGE;
					enable_c = 1'b0;
				end else if (!fits_q || !aligned_c) begin
					status_c = STAT_PARAM;
					enable_c = 1'b0;
				end else begin
					status_c = STAT_OK;
					enable_c = last_q;
					wr.en    = ctrl.finish;
				end
			end
			default: begin
				status_c = STAT_PARAM;
			end
		endcase
	end

	// Global enable and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= ctrl.finish;
			if (ctrl.finish) begin
				enable_q <= enable_c;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (ctrl.finish) begin
			status_q <= status_c;
			slot_q   <= slot_c;
		end
	end

	// A result is only shown once the sequencer has returned to idle.
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result strobe while a command is still in progress");

	// An accepted command keeps the block busy in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n) accept |=> busy)
		else $error("accepted command did not start the sequencer");

	// The scan only runs when there is at least one usable slot.
	assert property (@(posedge clk) disable iff (!arst_n) ctrl.scan |-> (eff_count != '0))
		else $error("slot scan with no usable slots");

	// A successful map or unmap always leaves the table enabled.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == STAT_OK) && (cmd_q != CMD_PROG)) |-> map_enabled)
		else $error("successful map or unmap left the enable cleared");

	// Status is never the unused code.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((status == STAT_OK) || (status == STAT_RANGE) || (status == STAT_PARAM)))
		else $error("result carries an undefined status code");

endmodule

// ===== sim/tb_address_region_map_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_address_region_map_table: self-checking bench for the region map table
// Directed commands run first, then phases of random map, unmap, program
// and unused-code commands under several slot counts. Each result is checked
// in order, field by field, against hand-written or in-bench model outcomes.
// ----------------------------------------------------------------------------
module tb_address_region_map_table;
	import armt_pkg::*;

	localparam logic [1:0]        CMD_UNUSED       = 2'd3;
	localparam int                CYCLE_LIMIT      = 600000;
	localparam int                RANDOM_PER_PHASE = 240;
	localparam int                DRAIN_CYCLES     = 24;
	localparam logic [BASE_W-1:0] TOP_PAGE         = 48'hFFFF_FFFF_F000;
	localparam logic [SIZE_W-1:0] FULL_SPACE       = 49'h1_0000_0000_0000;

	// One result as it appears on the result ports.
	typedef struct packed {
		logic [1:0]       status;
		logic [IDX_W-1:0] slot;
		logic             enabled;
	} outcome_t;

	// One command, with an optional hand-written expected outcome.
	typedef struct {
		logic [1:0]        op;
		logic [BASE_W-1:0] base;
		logic [SIZE_W-1:0] len;
		logic [TGT_W-1:0]  tgt;
		logic [IDX_W-1:0]  idx;
		logic              last;
		bit                typed;
		outcome_t          want;
	} cmd_row_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [1:0]          cmd;
	logic [BASE_W-1:0]   region_base;
	logic [SIZE_W-1:0]   region_size;
	logic [TGT_W-1:0]    dest_port;
	logic [IDX_W-1:0]    slot_index;
	logic                batch_last;
	logic                done;
	logic [1:0]          status;
	logic [IDX_W-1:0]    assigned_slot;
	logic                map_enabled;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [RC_W-1:0]     slot_limit;

	// Shadow copy of the table, the enable bit and the slot count register.
	logic                tbl_valid   [MAX_REGIONS];
	logic [PG_W-1:0]     tbl_base_pg [MAX_REGIONS];
	logic [PG_W-1:0]     tbl_end_pg  [MAX_REGIONS];
	logic [TGT_W-1:0]    tbl_tgt     [MAX_REGIONS];
	logic                tbl_enable;
	logic [RC_W-1:0]     tbl_slots;

	outcome_t            pending_outcomes[$];
	int                  mismatches;
	int                  cycles;
	cmd_row_t            directed_rows[21];
	logic [RC_W-1:0]     phase_counts[8];

	address_region_map_table uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.cmd           (cmd),
		.region_base   (region_base),
		.region_size   (region_size),
		.dest_port     (dest_port),
		.slot_index    (slot_index),
		.batch_last    (batch_last),
		.done          (done),
		.status        (status),
		.assigned_slot (assigned_slot),
		.map_enabled   (map_enabled),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.slot_limit    (slot_limit)
	);

	always #5 clk = ~clk;

	// Works out the outcome of one command and updates the shadow table.
	function automatic outcome_t apply_command(input cmd_row_t c);
		outcome_t         r;
		logic [SUM_W-1:0] span;
		logic [SUM_W-1:0] last_byte;
		logic [PG_W-1:0]  first_pg;
		logic [PG_W-1:0]  final_pg;
		int               usable;
		int               free_idx;
		int               i;
		bit               fits;
		bit               aligned_ok;
		bit               found;
		bit               hit;

		usable     = (int'(tbl_slots) < MAX_REGIONS) ? int'(tbl_slots) : MAX_REGIONS;
		span       = SUM_W'(c.base) + SUM_W'(c.len);
		last_byte  = span - SUM_W'(1);
		fits       = (c.len != '0) && (span <= (SUM_W'(1) << ADDR_BITS));
		aligned_ok = (c.base[PAGE_BITS-1:0] == '0) && (c.len[PAGE_BITS-1:0] == '0);
		first_pg   = c.base[ADDR_BITS-1:PAGE_BITS];
		final_pg   = last_byte[ADDR_BITS-1:PAGE_BITS];
		r.status   = STAT_OK;
		r.slot     = c.idx;
		found      = 1'b0;
		hit        = 1'b0;
		free_idx   = 0;

		case (c.op)
			CMD_MAP: begin
				r.slot = '0;
				if (!fits) begin
					r.status = STAT_PARAM;
				end else begin
					// Lowest free slot, and any overlap with a valid entry.
					for (i = 0; i < usable; i++) begin
						if (!tbl_valid[i]) begin
							if (!found) begin
								found    = 1'b1;
								free_idx = i;
							end
						end else if (first_pg <= tbl_end_pg[i] && tbl_base_pg[i] <= final_pg) begin
							hit = 1'b1;
						end
					end
					if (hit) begin
						r.status = STAT_PARAM;
					end else if (!found) begin
						r.status = STAT_RANGE;
					end else begin
						tbl_enable = 1'b0;
						if (!aligned_ok) begin
							r.status = STAT_PARAM;
						end else begin
							tbl_valid[free_idx]   = 1'b1;
							tbl_base_pg[free_idx] = first_pg;
							tbl_end_pg[free_idx]  = final_pg;
							tbl_tgt[free_idx]     = c.tgt;
							tbl_enable            = 1'b1;
							r.slot                = IDX_W'(free_idx);
						end
					end
				end
			end
			CMD_UNMAP: begin
				tbl_enable = 1'b0;
				if (int'(c.idx) >= usable) begin
					r.status = STAT_RANGE;
				end else begin
					tbl_valid[c.idx[SLOT_W-1:0]]   = 1'b0;
					tbl_base_pg[c.idx[SLOT_W-1:0]] = '0;
					tbl_end_pg[c.idx[SLOT_W-1:0]]  = '0;
					tbl_tgt[c.idx[SLOT_W-1:0]]     = '0;
					tbl_enable                     = 1'b1;
				end
			end
			CMD_PROG: begin
				tbl_enable = 1'b0;
				if (int'(c.idx) >= usable) begin
					r.status = STAT_RANGE;
				end else if (!fits || !aligned_ok) begin
					r.status = STAT_PARAM;
				end else begin
					// No overlap check for static programming.
					tbl_valid[c.idx[SLOT_W-1:0]]   = 1'b1;
					tbl_base_pg[c.idx[SLOT_W-1:0]] = first_pg;
					tbl_end_pg[c.idx[SLOT_W-1:0]]  = final_pg;
					tbl_tgt[c.idx[SLOT_W-1:0]]     = c.tgt;
					tbl_enable                     = c.last;
				end
			end
			default: begin
				r.status = STAT_PARAM;
			end
		endcase
		r.enabled = tbl_enable;
		return r;
	endfunction

	// Random command: mostly page-aligned regions in a narrow window so
	// that maps, overlaps and full tables all occur, with some noise.
	function automatic cmd_row_t random_command();
		cmd_row_t c;
		int       kind;
		int       pick;

		pick = $urandom_range(0, 99);
		if (pick < 45)
			c.op = CMD_MAP;
		else if (pick < 70)
			c.op = CMD_UNMAP;
		else if (pick < 95)
			c.op = CMD_PROG;
		else
			c.op = CMD_UNUSED;

		kind = $urandom_range(0, 99);
		if (kind < 55) begin
			c.base = BASE_W'($urandom_range(0, 47)) << PAGE_BITS;
			c.len  = SIZE_W'($urandom_range(1, 4)) << PAGE_BITS;
		end else if (kind < 70) begin
			c.base = (BASE_W'({$urandom, $urandom}) >> PAGE_BITS) << PAGE_BITS;
			c.len  = SIZE_W'($urandom_range(1, 3)) << PAGE_BITS;
		end else if (kind < 78) begin
			// Regions at the very top of the address space.
			c.base = TOP_PAGE - (BASE_W'($urandom_range(0, 3)) << PAGE_BITS);
			c.len  = SIZE_W'($urandom_range(1, 5)) << PAGE_BITS;
		end else if (kind < 88) begin
			c.base = BASE_W'({$urandom, $urandom});
			c.len  = SIZE_W'({$urandom, $urandom});
		end else if (kind < 95) begin
			// Misaligned base or size.
			c.base = BASE_W'($urandom_range(0, 47)) << PAGE_BITS;
			c.len  = SIZE_W'($urandom_range(1, 4)) << PAGE_BITS;
			if ($urandom_range(0, 1))
				c.base = c.base + BASE_W'($urandom_range(1, 4095));
			else
				c.len = c.len + SIZE_W'($urandom_range(1, 4095));
		end else begin
			// Zero size or a range past the end of the address space.
			c.base = BASE_W'($urandom_range(0, 47)) << PAGE_BITS;
			if ($urandom_range(0, 1))
				c.len = '0;
			else
				c.len = FULL_SPACE + (SIZE_W'($urandom_range(0, 4)) << PAGE_BITS);
		end

		c.tgt   = TGT_W'($urandom);
		c.idx   = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(0, 17));
		c.last  = 1'($urandom_range(0, 1));
		c.typed = 1'b0;
		c.want  = '0;
		return c;
	endfunction

	// Mostly back to back, sometimes short gaps, occasionally long ones.
	function automatic int pick_gap();
		int r;

		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	// Presents one command and holds it until the block takes it.
	task automatic issue_command(input cmd_row_t c);
		outcome_t predicted;

		@(negedge clk);
		cmd          = c.op;
		region_base  = c.base;
		region_size  = c.len;
		dest_port    = c.tgt;
		slot_index   = c.idx;
		batch_last   = c.last;
		start        = 1'b1;
		do
			@(posedge clk);
		while (busy);
		predicted = apply_command(c);
		pending_outcomes.push_back(c.typed ? c.want : predicted);
	endtask

	task automatic hold_off(input int n);
		if (n > 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// Stops issuing and waits until every outstanding result has come back.
	task automatic drain_results();
		@(negedge clk);
		start = 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_slot_count(input logic [RC_W-1:0] value);
		@(negedge clk);
		slot_limit = value;
		cfg_valid  = 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		tbl_slots = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Result checker: every done pulse is matched against the oldest outcome.
	always @(posedge clk) begin
		outcome_t exp_o;

		if (arst_n && done) begin
			if (pending_outcomes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("error: unexpected result status=%0d slot=%0d enable=%0b",
						status, assigned_slot, map_enabled);
			end else begin
				exp_o = pending_outcomes.pop_front();
				if (status !== exp_o.status || assigned_slot !== exp_o.slot ||
						map_enabled !== exp_o.enabled) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"error: expected status=%0d slot=%0d enable=%0b, ",
							"got status=%0d slot=%0d enable=%0b"},
							exp_o.status, exp_o.slot, exp_o.enabled,
							status, assigned_slot, map_enabled);
				end
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("address_region_map_table: mismatch");
			$finish;
		end
	end

	initial begin
		int       p;
		int       n;
		int       k;
		bit       steady;
		cmd_row_t c;

		clk          = 1'b0;
		arst_n       = 1'b0;
		start        = 1'b0;
		cmd          = CMD_MAP;
		region_base  = '0;
		region_size  = '0;
		dest_port    = '0;
		slot_index   = '0;
		batch_last   = 1'b0;
		cfg_valid    = 1'b0;
		slot_limit   = 5'd16;
		mismatches   = 0;
		cycles       = 0;

		// Shadow state as after reset.
		for (k = 0; k < MAX_REGIONS; k++) begin
			tbl_valid[k]   = 1'b0;
			tbl_base_pg[k] = '0;
			tbl_end_pg[k]  = '0;
			tbl_tgt[k]     = '0;
		end
		tbl_enable = 1'b0;
		tbl_slots  = 5'd16;

		// Directed commands, starting from the reset state with sixteen slots.
		directed_rows = '{
			// Unmap just past the last slot.
			'{CMD_UNMAP, 48'h0, 49'h0, 8'h00, 8'd16, 1'b0, 1'b1, '{STAT_RANGE, 8'd16, 1'b0}},
			// Zero-sized map.
			'{CMD_MAP, 48'h0, 49'h0, 8'h00, 8'hFF, 1'b1, 1'b1, '{STAT_PARAM, 8'd0, 1'b0}},
			// Map running off the end of the address space.
			'{CMD_MAP, TOP_PAGE, 49'h2000, 8'h00, 8'h00, 1'b0, 1'b1, '{STAT_PARAM, 8'd0, 1'b0}},
			// Misaligned size.
			'{CMD_MAP, 48'h1000, 49'h1001, 8'h00, 8'h00, 1'b0, 1'b1, '{STAT_PARAM, 8'd0, 1'b0}},
			// The whole address space in one region.
			'{CMD_MAP, 48'h0, FULL_SPACE, 8'h5A, 8'h00, 1'b0, 1'b1, '{STAT_OK, 8'd0, 1'b1}},
			// Overlap with it.
			'{CMD_MAP, 48'h1000, 49'h1000, 8'h00, 8'h00, 1'b0, 1'b1, '{STAT_PARAM, 8'd0, 1'b1}},
			'{CMD_UNMAP, 48'h0, 49'h0, 8'h00, 8'd0, 1'b0, 1'b1, '{STAT_OK, 8'd0, 1'b1}},
			// Topmost page.
			'{CMD_MAP, TOP_PAGE, 49'h1000, 8'hFF, 8'hFF, 1'b0, 1'b1, '{STAT_OK, 8'd0, 1'b1}},
			'{CMD_MAP, 48'h0, 49'h1000, 8'h00, 8'h00, 1'b1, 1'b0, '{STAT_OK, 8'd0, 1'b0}},
			// Misaligned base with a free slot clears the enable.
			'{CMD_MAP, 48'h1001, 49'h1000, 8'h00, 8'h00, 1'b0, 1'b0, '{STAT_OK, 8'd0, 1'b0}},
			'{CMD_PROG, 48'h5000, 49'h3000, 8'h11, 8'd255, 1'b1, 1'b1, '{STAT_RANGE, 8'd255, 1'b0}},
			'{CMD_PROG, 48'h5000, 49'h3000, 8'h22, 8'd15, 1'b0, 1'b1, '{STAT_OK, 8'd15, 1'b0}},
			// Overlapping program ending the batch.
			'{CMD_PROG, 48'h5000, 49'h1000, 8'h33, 8'd14, 1'b1, 1'b1, '{STAT_OK, 8'd14, 1'b1}},
			'{CMD_PROG, 48'h7000, 49'h0, 8'h44, 8'd3, 1'b1, 1'b1, '{STAT_PARAM, 8'd3, 1'b0}},
			'{CMD_PROG, 48'h123, 49'h1000, 8'h55, 8'd3, 1'b1, 1'b1, '{STAT_PARAM, 8'd3, 1'b0}},
			// Unused command code.
			'{CMD_UNUSED, 48'h0, 49'h0, 8'h00, 8'hAA, 1'b0, 1'b1, '{STAT_PARAM, 8'hAA, 1'b0}},
			'{CMD_MAP, 48'h5000, 49'h1000, 8'h66, 8'h00, 1'b0, 1'b0, '{STAT_OK, 8'd0, 1'b0}},
			'{CMD_MAP, 48'h0, 49'h1_FFFF_FFFF_FFFF, 8'h00, 8'h00, 1'b0, 1'b0, '{STAT_OK, 8'd0, 1'b0}},
			'{CMD_MAP, 48'hFFFF_FFFF_FFFF, 49'h1, 8'h00, 8'h00, 1'b0, 1'b0, '{STAT_OK, 8'd0, 1'b0}},
			'{CMD_PROG, TOP_PAGE, 49'h1000, 8'hFF, 8'd0, 1'b1, 1'b0, '{STAT_OK, 8'd0, 1'b0}},
			'{CMD_UNMAP, 48'h0, 49'h0, 8'h00, 8'd15, 1'b0, 1'b0, '{STAT_OK, 8'd0, 1'b0}}
		};

		// Slot counts for the random phases; both extremes included.
		phase_counts = '{5'd5, 5'd0, 5'd1, 5'd31, 5'd16, 5'd2, 5'd17, 5'd8};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			issue_command(directed_rows[i]);
			hold_off(pick_gap());
		end

		// Random phases, each under a fresh slot count.
		for (p = 0; p < $size(phase_counts); p++) begin
			drain_results();
			write_slot_count(phase_counts[p]);
			steady = (p % 3 == 0);
			for (n = 0; n < RANDOM_PER_PHASE; n++) begin
				c = random_command();
				issue_command(c);
				if ($urandom_range(0, 99) < 2)
					drain_results();
				else if (!steady)
					hold_off(pick_gap());
			end
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("address_region_map_table: match");
		else
			$display("address_region_map_table: mismatch");
		$finish;
	end

endmodule

// ===== address_region_map_table.f =====
hdl/armt_pkg.sv
hdl/armt_table.sv
hdl/armt_ovl.sv
hdl/armt_ctrl.sv
hdl/address_region_map_table.sv
sim/tb_address_region_map_table.sv
